FILE: hw/rtl/u2rt_pkg.sv
// Shared types, constants and the digit-to-ASCII mapping for the
// unsigned-to-radix text unit. No dependencies.
package u2rt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CHAR_ERR   = 8'h00;

  // Classified job handed from the front end to the conversion engine.
  typedef struct packed {
    logic               bad;
    logic [RADIX_W-1:0] radix;
  } u2rt_job_t;

  // Digits 0..9 map to '0'..'9', 10..35 to 'a'..'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + dw;
    end else begin
      digit_char = CHAR_LOW_A + dw - 8'd10;
    end
  endfunction

endpackage

FILE: hw/rtl/u2rt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u2rt_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/u2rt_front.sv
// Front end: accepts input values, flags an out-of-range base and queues
// the classified jobs in a two-entry FIFO. Depends on u2rt_pkg.
module u2rt_front #(
  parameter int unsigned VALUE_WIDTH = u2rt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [u2rt_pkg::RADIX_W-1:0]        radix_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [VALUE_WIDTH-1:0]              in_number_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output u2rt_pkg::u2rt_job_t                 job_o,
  output logic [VALUE_WIDTH-1:0]              number_o
);
  import u2rt_pkg::*;

  u2rt_job_t              job_mem_q [2];
  logic [VALUE_WIDTH-1:0] num_mem_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;
  u2rt_job_t              job_new;

  assign job_new.bad   = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);
  assign job_new.radix = radix_i;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = job_mem_q[rd_ptr_q];
  assign number_o    = num_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      job_mem_q[wr_ptr_q] <= job_new;
      num_mem_q[wr_ptr_q] <= in_number_i;
    end
  end

endmodule

FILE: hw/rtl/u2rt_back.sv
// Conversion engine: bit-serial division by the base, digit store in RAM,
// then digits emitted most significant first through an output register.
// Depends on u2rt_pkg and u2rt_ram.
module u2rt_back #(
  parameter int unsigned VALUE_WIDTH = u2rt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  u2rt_pkg::u2rt_job_t          job_i,
  input  logic [VALUE_WIDTH-1:0]       number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [u2rt_pkg::CHAR_W-1:0]  out_char_o,
  output logic                         out_last_o,
  output logic                         out_bad_o
);
  import u2rt_pkg::*;

  localparam int unsigned IdxW = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic [IdxW-1:0]       bit_q, bit_d;
  logic [IdxW-1:0]       wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  bad_q, bad_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  out_bad_q, out_bad_d;

  logic [RADIX_W:0]       trial, diff;
  logic                   ge;
  logic [RADIX_W-1:0]     rem_nxt;
  logic [VALUE_WIDTH-1:0] dvd_nxt;
  logic                   last_bit;
  logic                   ram_we;
  logic [RADIX_W-1:0]     ram_rdata;
  logic                   out_free;

  // One restoring-division step per cycle: quotient bits shift in at the bottom.
  assign trial    = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign ge       = trial >= {1'b0, radix_q};
  assign diff     = trial - {1'b0, radix_q};
  assign rem_nxt  = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  assign dvd_nxt  = {dvd_q[VALUE_WIDTH-2:0], ge};
  assign last_bit = (bit_q == IdxW'(VALUE_WIDTH - 1));
  assign ram_we   = (state_q == ST_DIV) && last_bit;
  assign out_free = !out_valid_q || out_ready_i;

  assign job_ready_o = (state_q == ST_IDLE);

  u2rt_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (rem_nxt),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    bit_d       = bit_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    bad_d       = bad_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          bad_d    = job_i.bad;
          radix_d  = job_i.radix;
          dvd_d    = number_i;
          rem_d    = '0;
          bit_d    = '0;
          wr_idx_d = '0;
          rd_idx_d = '0;
          state_d  = job_i.bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_nxt;
        dvd_d = dvd_nxt;
        bit_d = bit_q + 1'b1;
        if (last_bit) begin
          bit_d = '0;
          rem_d = '0;
          if (dvd_nxt == '0) begin
            rd_idx_d = wr_idx_q;
            state_d  = ST_READ;
          end else begin
            wr_idx_d = wr_idx_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        // wait for the registered read data
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = bad_q ? CHAR_ERR : digit_char(ram_rdata);
          out_last_d  = bad_q || (rd_idx_q == '0);
          out_bad_d   = bad_q;
          if (bad_q || (rd_idx_q == '0)) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    bit_q      <= bit_d;
    wr_idx_q   <= wr_idx_d;
    rd_idx_q   <= rd_idx_d;
    bad_q      <= bad_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

endmodule

FILE: hw/rtl/unsigned_to_radix_text_unit.sv
// Unsigned value to ASCII digits in a configurable base (2..36).
// Digits come from repeated bit-serial division by the base, are stored in
//   the digit RAM and are read back through its registered read port per char.
// The front queue holds up to two numbers; the engine starts the next number
//   only once the last character of the current one is in its output register.
// Reset (rst_ni low, async): radix returns to 10, queue and engine go empty.
module unsigned_to_radix_text_unit #(
  parameter int unsigned VALUE_WIDTH = u2rt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // base register write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [u2rt_pkg::RADIX_W-1:0]          cfg_data_i,      // radix
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,    // number, zero pad
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [u2rt_pkg::CHAR_W-1:0]           m_axis_tdata,    // char_code
  output logic                                  m_axis_tlast,    // last_char
  output logic                                  m_axis_tuser     // bad_radix
);
  import u2rt_pkg::*;

  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic                   job_valid, job_ready;
  u2rt_job_t              job;
  logic [VALUE_WIDTH-1:0] job_number;

  // The base register takes every write; the user must write it only when idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  assign radix_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  // Front end: classify the base and queue the job.
  u2rt_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_number_i (s_axis_tdata[VALUE_WIDTH-1:0]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job),
    .number_o    (job_number)
  );

  // Back end: divide, store digits, emit them most significant first.
  u2rt_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .number_i    (job_number),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_bad_o   (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // An error result is a single zero character that closes the item.
  a_bad_is_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == CHAR_ERR))
    else $error("bad-radix result is not a lone zero character");

  // Every regular result is a digit or a lowercase letter.
  a_char_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)) ||
      ((m_axis_tdata >= CHAR_LOW_A) && (m_axis_tdata <= CHAR_LOW_Z)))
    else $error("digit character out of range");

  // A job is handed over only when the engine is free for it.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> !job_ready)
    else $error("engine took a job without leaving idle");
`endif

endmodule

FILE: tb/unsigned_to_radix_text_unit_tb.sv
// Self-checking testbench for unsigned_to_radix_text_unit: directed table plus random
// numbers and bases, checked character by character against the table or a built-in digit predictor.
// Depends on u2rt_pkg and the unsigned_to_radix_text_unit RTL only.
module unsigned_to_radix_text_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2rt_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 5;
  // Quiet gap after a drain; the engine is already idle once every owed
  // character has come.
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES = 600_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned ITEMS_PER_BASE  = 16;

  // One output character as the block presents it.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_radix;
  } char_beat_t;

  // Directed row: base to use, number to send and, where obvious, the single
  // character it must give. Rows with typed = 0 go through the predictor.
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [15:0]        number;
    logic               typed;
    char_beat_t         beat;
  } text_row_t;

  localparam int unsigned N_ROWS = 19;
  localparam char_beat_t NO_BEAT = '{char_code: CHAR_ERR, last_char: 1'b0, bad_radix: 1'b0};
  localparam char_beat_t ERR_BEAT = '{char_code: CHAR_ERR, last_char: 1'b1, bad_radix: 1'b1};

  localparam text_row_t DIRECTED_ROWS [N_ROWS] = '{
    // reset base (10), no register write yet
    '{6'd10, 16'd0,     1'b1, '{CHAR_ZERO, 1'b1, 1'b0}},
    '{6'd10, 16'hFFFF,  1'b0, NO_BEAT},
    '{6'd10, 16'd9,     1'b1, '{CHAR_NINE, 1'b1, 1'b0}},
    '{6'd10, 16'd10,    1'b0, NO_BEAT},
    // base 2: the longest text, 16 characters
    '{6'd2,  16'hFFFF,  1'b0, NO_BEAT},
    '{6'd2,  16'h8000,  1'b0, NO_BEAT},
    '{6'd2,  16'd1,     1'b1, '{8'h31, 1'b1, 1'b0}},
    // base 36: full digit alphabet
    '{6'd36, 16'd35,    1'b1, '{CHAR_LOW_Z, 1'b1, 1'b0}},
    '{6'd36, 16'hFFFF,  1'b0, NO_BEAT},
    '{6'd36, 16'd0,     1'b1, '{CHAR_ZERO, 1'b1, 1'b0}},
    '{6'd16, 16'hA5C3,  1'b0, NO_BEAT},
    '{6'd16, 16'd15,    1'b1, '{8'h66, 1'b1, 1'b0}},
    // bases out of range on both sides, extremes of the register
    '{6'd0,  16'd1234,  1'b1, ERR_BEAT},
    '{6'd1,  16'd0,     1'b1, ERR_BEAT},
    '{6'd37, 16'd100,   1'b1, ERR_BEAT},
    '{6'd63, 16'hFFFF,  1'b1, ERR_BEAT},
    '{6'd35, 16'd34,    1'b1, '{8'h79, 1'b1, 1'b0}},
    '{6'd3,  16'hFFFF,  1'b0, NO_BEAT},
    '{6'd8,  16'h5555,  1'b0, NO_BEAT}
  };

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_data_i     = RADIX_RESET;
  logic               s_axis_tvalid  = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata   = '0;     // number
  logic               m_axis_tvalid;
  logic               m_axis_tready  = 1'b0;
  logic [CHAR_W-1:0]  m_axis_tdata;            // char_code
  logic               m_axis_tlast;            // last_char
  logic               m_axis_tuser;            // bad_radix

  char_beat_t         pending_chars[$];        // characters still owed by the block
  logic [RADIX_W-1:0] cur_radix      = RADIX_RESET;
  int unsigned        src_idle_pct   = 0;
  int unsigned        sink_stall_pct = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count    = 0;

  unsigned_to_radix_text_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver side: stall at the current rate, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Work out the characters one number gives in the given base, most
  // significant first, and queue them. A base outside 2..36 gives one error beat.
  function automatic void predict_text(input logic [15:0] value, input logic [RADIX_W-1:0] base);
    logic [RADIX_W-1:0] digits [16];
    logic [15:0]        rest;
    logic [RADIX_W-1:0] d;
    int                 n;
    int                 i;
    char_beat_t         beat;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      pending_chars.push_back(ERR_BEAT);
      return;
    end
    rest = value;
    n = 0;
    // Zero still yields one digit.
    do begin
      digits[n] = RADIX_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0);
    for (i = n - 1; i >= 0; i--) begin
      d = digits[i];
      beat.char_code = (d < 10) ? CHAR_ZERO + {2'b00, d} : CHAR_LOW_A + {2'b00, d} - 8'd10;
      beat.last_char = (i == 0);
      beat.bad_radix = 1'b0;
      pending_chars.push_back(beat);
    end
  endfunction

  // Compare every output transfer with the oldest owed character.
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected char: code=%h last=%b bad=%b",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.char_code || m_axis_tlast !== want.last_char ||
            m_axis_tuser !== want.bad_radix) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("char mismatch: expected code=%h last=%b bad=%b, got code=%h last=%b bad=%b",
                     want.char_code, want.last_char, want.bad_radix,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Drop valid, hold until every owed character has come, then let the
  // engine settle.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Change the base only with the block idle.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    hold_until_drained();
    cfg_data_i  <= r;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_radix = r;
  endtask

  // Offer one number, idling first at the current rate; return after the transfer.
  task automatic send_number(input logic [15:0] num);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= num;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly valid bases with the ends favored, some out of range on either side.
  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(9))
      0:       return RADIX_W'($urandom_range(1));
      1:       return RADIX_W'($urandom_range(63, 37));
      2:       return RADIX_MIN;
      3:       return RADIX_MAX;
      default: return RADIX_W'($urandom_range(36, 2));
    endcase
  endfunction

  function automatic logic [15:0] pick_number();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(40));
      3:       return 16'd1 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random numbers in runs of one base; force a full drain halfway through.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [15:0] num;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
      if (k % ITEMS_PER_BASE == 0)
        write_radix(pick_radix());
      if (k == ITEMS_PER_PHASE / 2 + 1)
        hold_until_drained();
      num = pick_number();
      send_number(num);
      predict_text(num, cur_radix);
    end
  endtask

  initial begin
    text_row_t row;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at full rate on both sides.
    for (int unsigned r = 0; r < N_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.radix != cur_radix)
        write_radix(row.radix);
      send_number(row.number);
      if (row.typed)
        pending_chars.push_back(row.beat);
      else
        predict_text(row.number, cur_radix);
    end

    // Random part: receiver-stall heavy, sender-idle heavy, then flat out.
    run_phase(24, 69);
    run_phase(69, 24);
    run_phase(0, 0);

    hold_until_drained();
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: unsigned_to_radix_text_unit.f
hw/rtl/u2rt_pkg.sv
hw/rtl/u2rt_ram.sv
hw/rtl/u2rt_front.sv
hw/rtl/u2rt_back.sv
hw/rtl/unsigned_to_radix_text_unit.sv
tb/unsigned_to_radix_text_unit_tb.sv
